// ===== rtl/fnpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fnpa_pkg
// shared constants, types and link encoding for the node pool allocator
// ----------------------------------------------------------------------------
package fnpa_pkg;

  localparam int unsigned ChunksPerBlock = 32;
  localparam int unsigned BlockSlots     = 8;
  localparam int unsigned TotalChunks    = ChunksPerBlock * BlockSlots;
  localparam int unsigned HandleW        = $clog2(TotalChunks);
  localparam int unsigned ChunkW         = $clog2(ChunksPerBlock);
  localparam int unsigned SlotW          = (BlockSlots > 1) ? $clog2(BlockSlots) : 1;
  localparam int unsigned CountW         = $clog2(ChunksPerBlock + 1);
  localparam int unsigned TotalW         = $clog2(TotalChunks + 1);
  // link word: pointer flag plus value (handle or remaining count)
  localparam int unsigned LinkValW       = (HandleW > ChunkW) ? HandleW : ChunkW;
  localparam int unsigned LinkW          = LinkValW + 1;
  localparam int unsigned SizeW          = 12;
  localparam int unsigned FreeHandleW    = 8;
  localparam int unsigned StepW          = $clog2(TotalChunks + 2);

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StOversize = 2'd1,
    StNoSlot   = 2'd2,
    StBadFree  = 2'd3
  } status_e;

  typedef struct packed {
    logic                   kind;
    logic [SizeW-1:0]       request_size;
    logic [FreeHandleW-1:0] free_handle;
  } req_t;

  typedef struct packed {
    logic [FreeHandleW-1:0] alloc_handle;
    logic [1:0]             status;
    logic [TotalW-1:0]      free_total;
    logic                   block_released;
  } rsp_t;

endpackage

// ===== rtl/fnpa_if.sv =====
// ----------------------------------------------------------------------------
// fnpa_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface fnpa_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/fnpa_ram.sv =====
// ----------------------------------------------------------------------------
// fnpa_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module fnpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== rtl/fixed_node_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_node_pool_allocator
// free-list node allocator over block slots held in one link ram
// ----------------------------------------------------------------------------
// Each input beat is an allocation or a free and yields one result beat. The
// chunk links live in a single-port ram with registered read. An allocation
// that follows a plain list pointer only reads the head chunk's link; one that
// unrolls a lazily threaded chunk also writes back its link and then, as one
// extra ram write, the remaining count, and one that also opens a new slot
// first makes one more write for the slot's head count. A free that releases a
// block walks the free list through the same ram port, bounded by the pool
// size. One item is in work at a time; the next input is taken as soon as the
// engine is idle, while a finished result waits in the output register. The
// engine holds its own result until that register is empty or being drained.
module fixed_node_pool_allocator
  import fnpa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SizeW-1:0] cfg_wdata_i,
  fnpa_if.sink             in_i,
  fnpa_if.source           out_o
);

  typedef enum logic [2:0] {
    SIdle, SRead, SAlloc, SWalkRd, SWalk, SDone
  } state_e;

  state_e               state_q;
  logic [LinkW-1:0]     head_q;
  logic [CountW-1:0]    bcnt_q [BlockSlots];
  logic [BlockSlots-1:0] bopen_q;
  logic [TotalW-1:0]    total_q;
  logic [SizeW-1:0]     adopt_q;
  logic [HandleW-1:0]   h_q;       // chunk being allocated / walk cursor
  logic [LinkW-1:0]     pred_q;    // walk predecessor (flag clear = head)
  logic                 skip_q;
  logic [StepW-1:0]     steps_q;
  logic [SlotW-1:0]     rblk_q;
  logic [FreeHandleW-1:0] res_handle_q;
  status_e              res_status_q;
  logic                 res_rel_q;
  rsp_t                 rsp_q;
  logic                 ovalid_q;

  logic                 ram_we;
  logic [HandleW-1:0]   ram_addr;
  logic [LinkW-1:0]     ram_wdata;
  logic [LinkW-1:0]     ram_rdata;

  fnpa_ram #(.Width(LinkW), .Depth(TotalChunks)) u_links (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  function automatic logic is_ptr(input logic [LinkW-1:0] l);
    return l[LinkW-1] && ({1'b0, l[LinkValW-1:0]} < (LinkValW+1)'(TotalChunks));
  endfunction

  function automatic logic [SlotW-1:0] blk_of(input logic [HandleW-1:0] h);
    return SlotW'(h >> ChunkW);
  endfunction

  function automatic logic [LinkW-1:0] mk_ptr(input logic [HandleW-1:0] h);
    return {1'b1, LinkValW'(h)};
  endfunction

  // lowest unopened slot
  logic             slot_found;
  logic [SlotW-1:0] slot_free;
  always_comb begin
    slot_found = 1'b0;
    slot_free  = '0;
    for (int s = BlockSlots - 1; s >= 0; s--) begin
      if (!bopen_q[s]) begin
        slot_found = 1'b1;
        slot_free  = SlotW'(s);
      end
    end
  end

  assign in_i.ready  = (state_q == SIdle);
  assign out_o.valid = ovalid_q;
  assign out_o.data  = rsp_q;

  // free request decode
  logic [SlotW-1:0]   fblk;
  logic [HandleW-1:0] fh;
  logic               fh_in;
  assign fh_in = {1'b0, in_i.data.free_handle} < (FreeHandleW+1)'(TotalChunks);
  assign fh    = HandleW'(in_i.data.free_handle);
  assign fblk  = blk_of(fh);

  // allocation unroll of the fetched link
  logic [LinkW-1:0] alloc_link;
  logic             alloc_wr;
  logic [ChunkW:0]  rem;
  always_comb begin
    alloc_link = ram_rdata;
    alloc_wr   = 1'b0;
    rem        = (ChunkW+1)'(ram_rdata[LinkValW-1:0]);
    if (!ram_rdata[LinkW-1]) begin
      alloc_wr = 1'b1;
      if ({1'b0, ram_rdata[LinkValW-1:0]} != '0 &&
          {1'b0, ram_rdata[LinkValW-1:0]} < (LinkValW+1)'(ChunksPerBlock) &&
          ({1'b0, h_q} + 1'b1) < (HandleW+1)'(TotalChunks)) begin
        alloc_link = mk_ptr(h_q + 1'b1);
      end else begin
        alloc_link = '0;
      end
    end
  end

  // walk block range test
  logic rd_in_blk;
  assign rd_in_blk = is_ptr(ram_rdata) && (blk_of(HandleW'(ram_rdata[LinkValW-1:0])) == rblk_q);
  logic steps_ok;
  assign steps_ok = steps_q <= StepW'(TotalChunks);

  // deferred ram write for a remaining count (unrolled chunk or new slot head)
  logic             fix_we_q;
  logic [HandleW-1:0] fix_addr_q;
  logic [LinkW-1:0] fix_data_q;

  // result beat moves into the output register
  logic rsp_load;
  assign rsp_load = (state_q == SDone) && !fix_we_q && (!ovalid_q || out_o.ready);

  // ram port mux, remainder-count write rides the port in otherwise idle cycles
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = h_q;
    ram_wdata = '0;
    unique case (state_q)
      SIdle: begin
        if (in_i.valid && in_i.ready && in_i.data.kind && fh_in &&
            bopen_q[fblk] && bcnt_q[fblk] < CountW'(ChunksPerBlock)) begin
          ram_we    = 1'b1;
          ram_addr  = fh;
          ram_wdata = is_ptr(head_q) ? head_q : '0;
        end
      end
      SRead: begin
        if (fix_we_q) begin
          ram_we    = 1'b1;
          ram_addr  = fix_addr_q;
          ram_wdata = fix_data_q;
        end
      end
      SAlloc: begin
        ram_we    = alloc_wr;
        ram_wdata = alloc_link;
        if (alloc_wr && alloc_link != '0) begin
          ram_addr  = h_q;
        end
      end
      SWalkRd: ram_addr = h_q;
      SWalk: begin
        ram_addr = HandleW'(pred_q[LinkValW-1:0]);
        if (!(rd_in_blk && steps_ok) && skip_q && pred_q[LinkW-1]) begin
          ram_we    = 1'b1;
          ram_wdata = is_ptr(ram_rdata) ? ram_rdata : '0;
        end
      end
      SDone: begin
        if (fix_we_q) begin
          ram_we    = 1'b1;
          ram_addr  = fix_addr_q;
          ram_wdata = fix_data_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      head_q   <= '0;
      bopen_q  <= '0;
      total_q  <= '0;
      adopt_q  <= '0;
      ovalid_q <= 1'b0;
      fix_we_q <= 1'b0;
      for (int b = 0; b < BlockSlots; b++) bcnt_q[b] <= '0;
    end else begin
      if (rsp_load) ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;
      if (cfg_we_i) adopt_q <= cfg_wdata_i;
      unique case (state_q)
        SIdle: begin
          if (in_i.valid && in_i.ready) begin
            res_handle_q <= '0;
            res_status_q <= StOk;
            res_rel_q    <= 1'b0;
            if (!in_i.data.kind) begin
              // allocation
              if (!is_ptr(head_q)) begin
                logic [SizeW-1:0] sz;
                sz = (adopt_q == '0) ? in_i.data.request_size : adopt_q;
                adopt_q <= sz;
                if (in_i.data.request_size > sz) begin
                  res_status_q <= StOversize;
                  state_q      <= SDone;
                end else if (!slot_found) begin
                  res_status_q <= StNoSlot;
                  state_q      <= SDone;
                end else begin
                  // open slot: its head link is the remaining count
                  h_q              <= HandleW'({slot_free, ChunkW'(0)});
                  bopen_q[slot_free] <= 1'b1;
                  bcnt_q[slot_free]  <= CountW'(ChunksPerBlock);
                  total_q          <= total_q + TotalW'(ChunksPerBlock);
                  fix_we_q         <= 1'b1;
                  fix_addr_q       <= HandleW'({slot_free, ChunkW'(0)});
                  fix_data_q       <= LinkW'(ChunksPerBlock - 1);
                  state_q          <= SRead;
                end
              end else if (in_i.data.request_size > adopt_q) begin
                res_status_q <= StOversize;
                state_q      <= SDone;
              end else begin
                h_q     <= HandleW'(head_q[LinkValW-1:0]);
                state_q <= SRead;
              end
            end else begin
              // free
              if (!fh_in || !bopen_q[fblk] || bcnt_q[fblk] >= CountW'(ChunksPerBlock)) begin
                res_status_q <= StBadFree;
                state_q      <= SDone;
              end else begin
                head_q       <= mk_ptr(fh);
                bcnt_q[fblk] <= bcnt_q[fblk] + 1'b1;
                total_q      <= total_q + 1'b1;
                if (bcnt_q[fblk] + 1'b1 == CountW'(ChunksPerBlock) &&
                    total_q + 1'b1 >= TotalW'(2 * ChunksPerBlock)) begin
                  rblk_q  <= fblk;
                  pred_q  <= '0;
                  h_q     <= fh;
                  // the new head is in the block, so it is skipped first
                  skip_q  <= 1'b1;
                  steps_q <= StepW'(1);
                  state_q <= SWalkRd;
                end else begin
                  state_q <= SDone;
                end
              end
            end
          end
        end
        SRead: begin
          if (fix_we_q) begin
            fix_we_q <= 1'b0;
            state_q  <= SRead;
          end else begin
            state_q <= SAlloc;
          end
        end
        SAlloc: begin
          logic [SlotW-1:0] b;
          b = blk_of(h_q);
          head_q <= is_ptr(alloc_link) ? alloc_link : '0;
          if (bcnt_q[b] != '0) bcnt_q[b] <= bcnt_q[b] - 1'b1;
          if (total_q != '0) total_q <= total_q - 1'b1;
          res_handle_q <= FreeHandleW'(h_q);
          if (alloc_wr && alloc_link != '0) begin
            fix_we_q   <= 1'b1;
            fix_addr_q <= h_q + 1'b1;
            fix_data_q <= LinkW'(rem - 1'b1);
          end
          state_q <= SDone;
        end
        SWalkRd: state_q <= SWalk;
        SWalk: begin
          // ram_rdata is link of cursor h_q
          if (rd_in_blk && steps_ok) begin
            h_q     <= HandleW'(ram_rdata[LinkValW-1:0]);
            skip_q  <= 1'b1;
            steps_q <= steps_q + 1'b1;
            state_q <= SWalkRd;
          end else begin
            if (skip_q && !pred_q[LinkW-1]) head_q <= is_ptr(ram_rdata) ? ram_rdata : '0;
            if (!is_ptr(ram_rdata) || !(steps_q + 1'b1 <= StepW'(TotalChunks))) begin
              total_q <= (total_q >= TotalW'(ChunksPerBlock)) ?
                         total_q - TotalW'(ChunksPerBlock) : '0;
              bopen_q[rblk_q] <= 1'b0;
              bcnt_q[rblk_q]  <= '0;
              res_rel_q       <= 1'b1;
              state_q <= SDone;
            end else begin
              pred_q  <= ram_rdata;
              h_q     <= HandleW'(ram_rdata[LinkValW-1:0]);
              skip_q  <= 1'b0;
              steps_q <= steps_q + 1'b1;
              state_q <= SWalkRd;
            end
          end
        end
        SDone: begin
          if (fix_we_q) begin
            fix_we_q <= 1'b0;
          end else if (rsp_load) begin
            rsp_q <= '{alloc_handle:   res_handle_q,
                       status:         res_status_q,
                       free_total:     total_q,
                       block_released: res_rel_q};
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the node pool allocator against a cycle-free model of its free list
// ----------------------------------------------------------------------------
// Every accepted request is run through a local model of the pool (lazy block
// threading, per-block counts, block release walk) and the expected response
// is queued. A monitor compares each response beat field by field with the
// oldest queued one. Named tests cover size adoption, oversize requests, bad
// frees, pool exhaustion, block release, double frees, output back-pressure
// and a long random mix under several node sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import fnpa_pkg::*;

  localparam int unsigned NullLinkVal = 0;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [SizeW-1:0] cfg_wdata_i;

  fnpa_if #(.T(req_t)) req_ch ();
  fnpa_if #(.T(rsp_t)) rsp_ch ();

  fixed_node_pool_allocator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (req_ch.sink),
    .out_o      (rsp_ch.source)
  );

  // pool model state
  bit          lk_ptr [TotalChunks];
  int unsigned lk_val [TotalChunks];
  bit          head_ptr;
  int unsigned head_val;
  int unsigned blk_cnt [BlockSlots];
  bit          blk_open [BlockSlots];
  int unsigned free_cnt;
  int unsigned adopt_size;

  rsp_t        pending_results [$];
  int unsigned live_handles [$];
  int unsigned freed_handles [$];
  int unsigned fail_count;
  bit          idle_on;
  bit          hold_req;
  int          hold_left;
  int          stall_left;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #60ms;
    $display("status: fail");
    $finish;
  end

  function automatic void pool_reset();
    for (int i = 0; i < TotalChunks; i++) begin
      lk_ptr[i] = 1'b0;
      lk_val[i] = NullLinkVal;
    end
    head_ptr = 1'b0;
    head_val = NullLinkVal;
    for (int s = 0; s < BlockSlots; s++) begin
      blk_cnt[s]  = 0;
      blk_open[s] = 1'b0;
    end
    free_cnt   = 0;
    adopt_size = 0;
  endfunction

  // unlink every chunk of one block from the free list, walk bounded to pool size
  function automatic void release_block(int unsigned blk);
    int unsigned lo;
    int unsigned hi;
    int unsigned pred;
    int unsigned steps;
    bit          cp;
    int unsigned cv;
    bit          skipped;
    lo    = blk * ChunksPerBlock;
    hi    = lo + ChunksPerBlock;
    pred  = TotalChunks;
    steps = 0;
    cp    = head_ptr;
    cv    = head_val;
    while (cp && steps <= TotalChunks) begin
      skipped = 1'b0;
      while (cp && cv >= lo && cv < hi && steps <= TotalChunks) begin
        {cp, cv} = {lk_ptr[cv], lk_val[cv]};
        skipped  = 1'b1;
        steps++;
      end
      if (skipped) begin
        if (pred >= TotalChunks) begin
          head_ptr = cp;
          head_val = cp ? cv : NullLinkVal;
        end else begin
          lk_ptr[pred] = cp;
          lk_val[pred] = cp ? cv : NullLinkVal;
        end
      end
      if (!cp) break;
      pred = cv;
      cp   = lk_ptr[pred];
      cv   = lk_val[pred];
      steps++;
    end
    free_cnt      = (free_cnt >= ChunksPerBlock) ? free_cnt - ChunksPerBlock : 0;
    blk_open[blk] = 1'b0;
    blk_cnt[blk]  = 0;
  endfunction

  function automatic rsp_t pool_outcome(req_t r);
    rsp_t        o;
    bit          ok;
    int unsigned s;
    int unsigned h;
    int unsigned blk;
    int unsigned n;
    bit          lp;
    int unsigned lv;
    o  = '0;
    ok = 1'b1;
    if (r.kind == 1'b0) begin
      if (!head_ptr) begin
        if (adopt_size == 0) adopt_size = r.request_size;
        if (r.request_size > adopt_size) begin
          o.status = StOversize;
          ok = 1'b0;
        end else begin
          for (s = 0; s < BlockSlots; s++) if (!blk_open[s]) break;
          if (s >= BlockSlots) begin
            o.status = StNoSlot;
            ok = 1'b0;
          end else begin
            lk_ptr[s*ChunksPerBlock] = 1'b0;
            lk_val[s*ChunksPerBlock] = ChunksPerBlock - 1;
            head_ptr    = 1'b1;
            head_val    = s * ChunksPerBlock;
            blk_open[s] = 1'b1;
            blk_cnt[s]  = ChunksPerBlock;
            free_cnt   += ChunksPerBlock;
          end
        end
      end else if (r.request_size > adopt_size) begin
        o.status = StOversize;
        ok = 1'b0;
      end
      if (ok) begin
        h   = head_val;
        blk = h / ChunksPerBlock;
        lp  = lk_ptr[h];
        lv  = lk_val[h];
        // unroll one chunk of a lazily threaded block
        if (!lp) begin
          n = lv;
          if (n > 0 && n < ChunksPerBlock && h + 1 < TotalChunks) begin
            lk_ptr[h+1] = 1'b0;
            lk_val[h+1] = n - 1;
            lp = 1'b1;
            lv = h + 1;
          end else begin
            lp = 1'b0;
            lv = NullLinkVal;
          end
          lk_ptr[h] = lp;
          lk_val[h] = lv;
        end
        head_ptr = lp;
        head_val = lp ? lv : NullLinkVal;
        if (blk_cnt[blk] > 0) blk_cnt[blk]--;
        if (free_cnt > 0) free_cnt--;
        o.alloc_handle = h[FreeHandleW-1:0];
      end
    end else begin
      h   = r.free_handle;
      blk = h / ChunksPerBlock;
      if (h >= TotalChunks || !blk_open[blk] || blk_cnt[blk] >= ChunksPerBlock) begin
        o.status = StBadFree;
      end else begin
        lk_ptr[h] = head_ptr;
        lk_val[h] = head_ptr ? head_val : NullLinkVal;
        head_ptr  = 1'b1;
        head_val  = h;
        blk_cnt[blk]++;
        free_cnt++;
        if (blk_cnt[blk] == ChunksPerBlock && free_cnt >= 2 * ChunksPerBlock) begin
          release_block(blk);
          o.block_released = 1'b1;
        end
      end
    end
    o.free_total = free_cnt[TotalW-1:0];
    return o;
  endfunction

  // offer one request beat, model it on acceptance
  task automatic send_item(bit kind, int unsigned size, int unsigned fh);
    req_t r;
    rsp_t o;
    r.kind         = kind;
    r.request_size = size[SizeW-1:0];
    r.free_handle  = fh[FreeHandleW-1:0];
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    o = pool_outcome(r);
    pending_results.insert(pending_results.size(), o);
    if (kind == 1'b0 && o.status == StOk) begin
      live_handles.insert(live_handles.size(), o.alloc_handle);
    end
  endtask

  task automatic send_alloc(int unsigned size);
    send_item(1'b0, size, $urandom_range(0, 255));
  endtask

  task automatic send_free(int unsigned fh);
    send_item(1'b1, $urandom_range(0, 4095), fh);
  endtask

  // free a random live handle
  task automatic free_live();
    int unsigned idx;
    int unsigned h;
    idx = $urandom_range(0, live_handles.size() - 1);
    h   = live_handles[idx];
    live_handles.delete(idx);
    freed_handles.insert(freed_handles.size(), h);
    if (freed_handles.size() > 16) void'(freed_handles.pop_front());
    send_free(h);
  endtask

  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_node_size(int unsigned v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v[SizeW-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    adopt_size = v;
  endtask

  // first allocation adopts its size, oversize and bad frees
  task automatic test_adopt_and_errors();
    write_node_size(0);
    send_alloc(100);
    send_alloc(101);
    send_alloc(100);
    send_alloc(0);
    send_free(40);
    send_free(255);
    send_free(1);
    send_free(0);
    send_free(2);
    send_free(5);
    void'(live_handles.pop_front());
    void'(live_handles.pop_front());
    void'(live_handles.pop_front());
    send_alloc(4095);
    send_alloc(50);
  endtask

  // exhaust every slot, then free everything so blocks get released
  task automatic test_fill_and_release();
    write_node_size(4095);
    for (int i = 0; i < TotalChunks + 2; i++) send_alloc((i % 2) ? 4095 : 0);
    while (live_handles.size() != 0) free_live();
  endtask

  // free the same chunk twice, list gets corrupted on purpose
  task automatic test_double_free();
    write_node_size(1);
    for (int i = 0; i < 40; i++) send_alloc($urandom_range(0, 1));
    for (int i = 0; i < 4; i++) free_live();
    send_free(freed_handles[freed_handles.size() - 1]);
    send_free(freed_handles[0]);
    while (live_handles.size() != 0) free_live();
    send_alloc(2);
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_backpressure();
    write_node_size(12);
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (live_handles.size() != 0 && $urandom_range(0, 2) == 0) free_live();
      else send_alloc($urandom_range(0, 12));
    end
  endtask

  // random mix in growing and shrinking phases
  task automatic test_random_mix(int unsigned n_items, int unsigned size_cfg);
    int unsigned alloc_pct;
    int unsigned pick;
    write_node_size(size_cfg);
    for (int i = 0; i < n_items; i++) begin
      alloc_pct = ((i / 120) % 2 == 0) ? 75 : 25;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_free($urandom_range(0, 255));
      end else if (pick < 8 && freed_handles.size() != 0) begin
        send_free(freed_handles[$urandom_range(0, freed_handles.size() - 1)]);
      end else if (pick < 12) begin
        send_alloc($urandom_range(0, 4095));
      end else if ($urandom_range(0, 99) < alloc_pct || live_handles.size() == 0) begin
        send_alloc($urandom_range(0, adopt_size));
      end else begin
        free_live();
      end
    end
  endtask

  // receiver ready with random stalls and a counted hold-off
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 5);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // response check against oldest expectation
  always @(posedge clk_i) begin
    rsp_t exp_r;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("response beat with nothing expected");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (rsp_ch.data.alloc_handle !== exp_r.alloc_handle) begin
          $error("alloc_handle exp %0d got %0d", exp_r.alloc_handle,
                 rsp_ch.data.alloc_handle);
          fail_count++;
        end
        if (rsp_ch.data.status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, rsp_ch.data.status);
          fail_count++;
        end
        if (rsp_ch.data.free_total !== exp_r.free_total) begin
          $error("free_total exp %0d got %0d", exp_r.free_total,
                 rsp_ch.data.free_total);
          fail_count++;
        end
        if (rsp_ch.data.block_released !== exp_r.block_released) begin
          $error("block_released exp %0d got %0d", exp_r.block_released,
                 rsp_ch.data.block_released);
          fail_count++;
        end
      end
    end
  end

  // main sequence
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    fail_count   = 0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    hold_left    = 0;
    stall_left   = 0;
    pool_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_adopt_and_errors();
    test_fill_and_release();
    test_double_free();
    test_backpressure();
    test_random_mix(450, 4095);
    test_random_mix(350, 1);
    test_random_mix(200, $urandom_range(2, 4094));
    idle_on = 1'b0;
    test_random_mix(300, 4095);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      if (pending_results.size() != 0) $error("%0d responses never came", pending_results.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
